// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the tokenizer core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is active
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: src/pwt_pkg.sv
// ----------------------------------------------------------------------------
// pwt_pkg
// Types and codes shared by the wire-format tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pwt_pkg;

  // decoder phase, one-hot
  typedef enum logic [5:0] {
    PH_TAG     = 6'b000001,
    PH_VARVAL  = 6'b000010,
    PH_FIXED   = 6'b000100,
    PH_LEN     = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_DISCARD = 6'b100000
  } phase_e;

  // token kinds
  localparam logic [2:0] KIND_VARINT  = 3'd0;
  localparam logic [2:0] KIND_FIXED64 = 3'd1;
  localparam logic [2:0] KIND_FIXED32 = 3'd2;
  localparam logic [2:0] KIND_LENGTH  = 3'd3;
  localparam logic [2:0] KIND_PAYLOAD = 3'd4;
  localparam logic [2:0] KIND_ERROR   = 3'd5;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERLONG  = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED = 2'd2;
  localparam logic [1:0] ERR_BAD_WIRE  = 2'd3;

  // wire types
  localparam logic [2:0] WIRE_VARINT  = 3'd0;
  localparam logic [2:0] WIRE_FIXED64 = 3'd1;
  localparam logic [2:0] WIRE_LENGTH  = 3'd2;
  localparam logic [2:0] WIRE_FIXED32 = 3'd5;

  // index of the tenth varint byte
  localparam logic [3:0] VARINT_LAST_CNT = 4'd9;

  // decoder state carried from byte to byte
  typedef struct packed {
    phase_e        phase;
    logic [63:0]   acc;
    logic [3:0]    cnt;
    logic [31:0]   field;
    logic [2:0]    wire_t;
    logic [63:0]   rem;
  } dec_state_t;

  localparam dec_state_t DEC_STATE_RESET = '{
    phase:  PH_TAG,
    acc:    64'd0,
    cnt:    4'd0,
    field:  32'd0,
    wire_t: 3'd0,
    rem:    64'd0
  };

  // one result token
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] field;
    logic [2:0]  wire_t;
    logic [63:0] value;
    logic [1:0]  err;
    logic        payload_last;
    logic        message_end;
  } token_t;

endpackage

`default_nettype wire

// File: src/pwt_decode.sv
// ----------------------------------------------------------------------------
// pwt_decode
// Per-byte decode step: next decoder state and the token this byte yields.
// ----------------------------------------------------------------------------
`default_nettype none

module pwt_decode (
  input  pwt_pkg::dec_state_t st_i,
  input  logic [7:0]          byte_i,
  input  logic                fin_i,
  output pwt_pkg::dec_state_t st_o,
  output logic                tok_valid_o,
  output pwt_pkg::token_t     tok_o
);
  import pwt_pkg::*;

  logic [6:0]  var_sh;
  logic [5:0]  fix_sh;
  logic [63:0] var_acc;
  logic [63:0] fix_acc;
  logic        cont;
  logic        overlong;
  logic        rem_last;
  logic        err_v;
  logic [1:0]  err_code;
  logic [31:0] err_field;
  logic [2:0]  err_wire;
  logic [31:0] tag_field;
  logic [2:0]  tag_wire;

  // accumulator updates for varint and little-endian fixed bytes
  assign var_sh   = {3'b000, st_i.cnt} * 7'd7;
  assign fix_sh   = {st_i.cnt[2:0], 3'b000};
  assign var_acc  = st_i.acc | ({57'd0, byte_i[6:0]} << var_sh);
  assign fix_acc  = st_i.acc | ({56'd0, byte_i} << fix_sh);
  assign cont     = byte_i[7];
  assign overlong = cont && (st_i.cnt == VARINT_LAST_CNT);
  assign rem_last = (st_i.rem <= 64'd1);
  assign tag_field = var_acc[34:3];
  assign tag_wire  = var_acc[2:0];

  always_comb begin
    st_o        = st_i;
    tok_valid_o = 1'b0;
    tok_o       = '0;
    err_v       = 1'b0;
    err_code    = ERR_NONE;
    err_field   = 32'd0;
    err_wire    = 3'd0;

    unique case (st_i.phase)
      // tag varint
      PH_TAG: begin
        if (overlong) begin
          err_v    = 1'b1;
          err_code = ERR_OVERLONG;
        end else if (cont) begin
          if (fin_i) begin
            err_v    = 1'b1;
            err_code = ERR_TRUNCATED;
          end else begin
            st_o.acc = var_acc;
            st_o.cnt = st_i.cnt + 4'd1;
          end
        end else begin
          st_o.acc    = 64'd0;
          st_o.cnt    = 4'd0;
          st_o.rem    = 64'd0;
          st_o.field  = tag_field;
          st_o.wire_t = tag_wire;
          case (tag_wire)
            WIRE_VARINT:  st_o.phase = PH_VARVAL;
            WIRE_FIXED64: begin
              st_o.phase = PH_FIXED;
              st_o.rem   = 64'd8;
            end
            WIRE_FIXED32: begin
              st_o.phase = PH_FIXED;
              st_o.rem   = 64'd4;
            end
            WIRE_LENGTH:  st_o.phase = PH_LEN;
            default: begin
              err_v    = 1'b1;
              err_code = ERR_BAD_WIRE;
            end
          endcase
          if (!err_v && fin_i) begin
            err_v    = 1'b1;
            err_code = ERR_TRUNCATED;
          end
          err_field = tag_field;
          err_wire  = tag_wire;
        end
      end

      // varint value or length header
      PH_VARVAL, PH_LEN: begin
        err_field = st_i.field;
        err_wire  = st_i.wire_t;
        if (overlong) begin
          err_v    = 1'b1;
          err_code = ERR_OVERLONG;
        end else if (cont) begin
          if (fin_i) begin
            err_v    = 1'b1;
            err_code = ERR_TRUNCATED;
          end else begin
            st_o.acc = var_acc;
            st_o.cnt = st_i.cnt + 4'd1;
          end
        end else begin
          st_o.acc          = 64'd0;
          st_o.cnt          = 4'd0;
          st_o.rem          = 64'd0;
          tok_o.field       = st_i.field;
          tok_o.wire_t      = st_i.wire_t;
          tok_o.value       = var_acc;
          tok_o.message_end = fin_i;
          if (st_i.phase == PH_VARVAL) begin
            st_o.phase  = PH_TAG;
            tok_valid_o = 1'b1;
            tok_o.kind  = KIND_VARINT;
          end else if (var_acc == 64'd0) begin
            st_o.phase  = PH_TAG;
            tok_valid_o = 1'b1;
            tok_o.kind  = KIND_LENGTH;
          end else if (fin_i) begin
            err_v    = 1'b1;
            err_code = ERR_TRUNCATED;
          end else begin
            st_o.rem    = var_acc;
            st_o.phase  = PH_PAYLOAD;
            tok_valid_o = 1'b1;
            tok_o.kind  = KIND_LENGTH;
          end
        end
      end

      // fixed64 or fixed32 body
      PH_FIXED: begin
        err_field = st_i.field;
        err_wire  = st_i.wire_t;
        if (rem_last) begin
          st_o.acc          = 64'd0;
          st_o.cnt          = 4'd0;
          st_o.rem          = 64'd0;
          st_o.phase        = PH_TAG;
          tok_valid_o       = 1'b1;
          tok_o.kind        = (st_i.wire_t == WIRE_FIXED64) ? KIND_FIXED64 : KIND_FIXED32;
          tok_o.field       = st_i.field;
          tok_o.wire_t      = st_i.wire_t;
          tok_o.value       = fix_acc;
          tok_o.message_end = fin_i;
        end else if (fin_i) begin
          err_v    = 1'b1;
          err_code = ERR_TRUNCATED;
        end else begin
          st_o.acc = fix_acc;
          st_o.cnt = st_i.cnt + 4'd1;
          st_o.rem = st_i.rem - 64'd1;
        end
      end

      // length-delimited payload bytes
      PH_PAYLOAD: begin
        err_field    = st_i.field;
        err_wire     = st_i.wire_t;
        tok_o.kind   = KIND_PAYLOAD;
        tok_o.field  = st_i.field;
        tok_o.wire_t = st_i.wire_t;
        tok_o.value  = {56'd0, byte_i};
        if (rem_last) begin
          st_o.acc           = 64'd0;
          st_o.cnt           = 4'd0;
          st_o.rem           = 64'd0;
          st_o.phase         = PH_TAG;
          tok_valid_o        = 1'b1;
          tok_o.payload_last = 1'b1;
          tok_o.message_end  = fin_i;
        end else if (fin_i) begin
          err_v    = 1'b1;
          err_code = ERR_TRUNCATED;
        end else begin
          st_o.rem    = st_i.rem - 64'd1;
          tok_valid_o = 1'b1;
        end
      end

      // drop bytes up to the end of the message
      PH_DISCARD: begin
        if (fin_i) begin
          st_o = DEC_STATE_RESET;
        end
      end

      default: begin
        st_o = DEC_STATE_RESET;
      end
    endcase

    // error token replaces whatever this byte would have given
    if (err_v) begin
      tok_valid_o       = 1'b1;
      tok_o             = '0;
      tok_o.kind        = KIND_ERROR;
      tok_o.field       = err_field;
      tok_o.wire_t      = err_wire;
      tok_o.err         = err_code;
      tok_o.message_end = fin_i;
      st_o              = DEC_STATE_RESET;
      st_o.phase        = fin_i ? PH_TAG : PH_DISCARD;
    end
  end

endmodule

`default_nettype wire

// File: src/pwt_out_reg.sv
// ----------------------------------------------------------------------------
// pwt_out_reg
// Result register holding one token until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pwt_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  pwt_pkg::token_t tok_i,
  input  logic            tready_i,
  output logic            tvalid_o,
  output pwt_pkg::token_t tok_o
);
  import pwt_pkg::*;

  logic   valid_q, valid_d;
  token_t tok_q;

  // user loads only when the register is empty or being drained; not enforced
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // token payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tok_q <= tok_i;
    end
  end

  assign tvalid_o = valid_q;
  assign tok_o    = tok_q;

endmodule

`default_nettype wire

// File: src/protobuf_wire_tokenizer_core.sv
// ----------------------------------------------------------------------------
// protobuf_wire_tokenizer_core
// Byte-serial protobuf wire-format tokenizer with stream in and out ports.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one message byte per beat in s_axis_tdata_i, with
//   s_axis_tlast_i high on the last byte of a message.
//   Output channel: at most one token per input byte. tuser carries the token
//   kind and the payload-last flag, tlast marks the token that closes the
//   message, tdata carries field number, wire type, value and error code.
//   Timing: an accepted byte is registered in the input register, decoded
//   into the result register once that slot is free, and its token is
//   valid from then on. Throughput: one byte per cycle sustained while the
//   token receiver keeps tready high; the combinational decode step (varint/fixed
//   accumulate plus 64-bit remaining-count update) sets it. Bytes that give no
//   token (tag bytes, inner varint bytes) still take a decode step each.
//   Stall: while a token waits in the result register, the input register
//   holds one more byte; the input side stalls only when both are full.
//   Reset: clears the input and result valid flags and returns the decoder
//   to expecting a tag with all counters cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module protobuf_wire_tokenizer_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] in_byte
  input  logic         s_axis_tlast_i,   // final_byte
  // token stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [103:0] m_axis_tdata_o,   // [31:0] field_number, [34:32] wire_kind,
                                         // [98:35] field_value, [100:99] error_code,
                                         // [103:101] zero
  output logic [3:0]   m_axis_tuser_o,   // [2:0] token_kind, [3] payload_last
  output logic         m_axis_tlast_o    // message_end
);
  import pwt_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_fin_q;
  logic       advance;
  logic       out_valid;
  dec_state_t st_q, st_d;
  logic       tok_valid;
  token_t     tok_next;
  token_t     tok_out;

  // the decode step runs when a byte is held and the result slot is free or draining
  assign advance         = in_valid_q && (!out_valid || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // input register
  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_fin_q  <= s_axis_tlast_i;
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= DEC_STATE_RESET;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  pwt_decode u_decode (
    .st_i        (st_q),
    .byte_i      (in_byte_q),
    .fin_i       (in_fin_q),
    .st_o        (st_d),
    .tok_valid_o (tok_valid),
    .tok_o       (tok_next)
  );

  pwt_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && tok_valid),
    .tok_i    (tok_next),
    .tready_i (m_axis_tready_i),
    .tvalid_o (out_valid),
    .tok_o    (tok_out)
  );

  // output packing
  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {3'b000, tok_out.err, tok_out.value, tok_out.wire_t, tok_out.field};
  assign m_axis_tuser_o  = {tok_out.payload_last, tok_out.kind};
  assign m_axis_tlast_o  = tok_out.message_end;

  // an error inside a message leaves the decoder discarding
  `ASSERT_NEXT(a_err_discard, clk_i, rst_ni,
    advance && tok_valid && (tok_next.kind == KIND_ERROR) && !in_fin_q,
    st_q.phase == PH_DISCARD)

  // bytes dropped after an error give no token
  `ASSERT_IMPLIES(a_discard_silent, clk_i, rst_ni,
    advance && (st_q.phase == PH_DISCARD), !tok_valid)

  // payload-last only rides on payload tokens
  `ASSERT_IMPLIES(a_plast_kind, clk_i, rst_ni,
    m_axis_tvalid_o && m_axis_tuser_o[3], m_axis_tuser_o[2:0] == KIND_PAYLOAD)

endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream-level testbench for the protobuf wire-format tokenizer. Byte beats
// are fed one message at a time: a short directed run, then random messages
// of varint, fixed, and length-delimited fields, with cut-short messages,
// overlong varints, unknown wire types and noise mixed in. A built-in decoder
// model predicts each token, and every token taken from the output is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import pwt_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_BYTES   = 515;
  localparam int TAIL_BYTES     = 60;
  localparam int HOLD_AT_BYTE   = 260;
  localparam int HOLD_CYCLES    = 120;
  localparam int SETTLE_CYCLES  = 16;
  localparam int MODE_PERIOD    = 48;
  localparam int MAX_REPORTS    = 10;
  localparam int TIMEOUT_NS     = 1_000_000;

  // varint encoding
  localparam int          VARINT_MAX_BYTES = 10;
  localparam logic [7:0]  VARINT_MORE      = 8'h80;
  localparam logic [63:0] VARINT_LOW_MASK  = 64'h7f;

  // fixed field sizes in bytes
  localparam logic [63:0] FIXED64_BYTES = 64'd8;
  localparam logic [63:0] FIXED32_BYTES = 64'd4;

  // wire types the decoder rejects
  localparam logic [2:0] WIRE_GROUP_START = 3'd3;
  localparam logic [2:0] WIRE_GROUP_END   = 3'd4;
  localparam logic [2:0] WIRE_RSVD6       = 3'd6;
  localparam logic [2:0] WIRE_RSVD7       = 3'd7;

  typedef enum logic [1:0] {VB_MORE, VB_DONE, VB_OVERLONG} varint_step_e;

  // one message byte waiting to be sent; drain holds it back until no token is due
  typedef struct packed {
    logic       drain;
    logic       last;
    logic [7:0] data;
  } msg_byte_t;

  logic         clk_i    = 1'b0;
  logic         rst_ni   = 1'b0;
  logic         s_tvalid = 1'b0;
  logic [7:0]   s_tdata  = 8'd0;
  logic         s_tlast  = 1'b0;
  logic         m_tready = 1'b0;
  logic         s_tready;
  logic         m_tvalid;
  logic [103:0] m_tdata;
  logic [3:0]   m_tuser;
  logic         m_tlast;

  protobuf_wire_tokenizer_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  msg_byte_t byte_feed[$];
  logic [7:0] msg_buf[$];
  token_t    tokens_due[$];

  int  bytes_in   = 0;
  int  mismatches = 0;
  bit  in_fire    = 1'b0;
  bit  rx_hold    = 1'b0;

  // decoder model state
  phase_e      dec_phase  = PH_TAG;
  logic [63:0] dec_acc    = 64'd0;
  logic [6:0]  dec_shift  = 7'd0;
  logic [31:0] dec_field  = 32'd0;
  logic [2:0]  dec_wire   = 3'd0;
  logic [63:0] dec_remain = 64'd0;

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // decoder model
  // ---------------------------------------------------------------------------

  function automatic void clear_body();
    dec_acc    = 64'd0;
    dec_shift  = 7'd0;
    dec_remain = 64'd0;
  endfunction

  // fold one varint byte into the accumulator
  function automatic varint_step_e varint_take(input logic [7:0] b);
    if (dec_shift < 7'd64) dec_acc = dec_acc | ((b & VARINT_LOW_MASK) << dec_shift);
    if (!b[7]) return VB_DONE;
    dec_shift = dec_shift + 7'd7;
    if (dec_shift >= 7'd64) return VB_OVERLONG;
    return VB_MORE;
  endfunction

  function automatic token_t field_token(input logic [2:0] kind, input logic [63:0] value,
                                         input logic plast, input logic fin);
    token_t t;
    t = '{kind: kind, field: dec_field, wire_t: dec_wire, value: value, err: ERR_NONE,
          payload_last: plast, message_end: fin};
    return t;
  endfunction

  // error token; drops the field and discards up to the final byte
  function automatic token_t error_token(input logic [1:0] code, input logic [31:0] fld,
                                         input logic [2:0] wt, input logic fin);
    token_t t;
    t = '{kind: KIND_ERROR, field: fld, wire_t: wt, value: 64'd0, err: code,
          payload_last: 1'b0, message_end: fin};
    clear_body();
    dec_field = 32'd0;
    dec_wire  = 3'd0;
    dec_phase = fin ? PH_TAG : PH_DISCARD;
    return t;
  endfunction

  task automatic tokenize_byte(input logic [7:0] b, input logic fin);
    token_t       t;
    bit           hit;
    varint_step_e r;
    logic [63:0]  v;
    hit = 1'b0;
    case (dec_phase)
      PH_TAG: begin
        r = varint_take(b);
        if (r == VB_OVERLONG) begin
          t   = error_token(ERR_OVERLONG, 32'd0, 3'd0, fin);
          hit = 1'b1;
        end else if (r == VB_MORE) begin
          if (fin) begin
            t   = error_token(ERR_TRUNCATED, 32'd0, 3'd0, fin);
            hit = 1'b1;
          end
        end else begin
          v = dec_acc;
          clear_body();
          dec_field = v[34:3];
          dec_wire  = v[2:0];
          case (dec_wire)
            WIRE_VARINT: begin
              dec_phase = PH_VARVAL;
            end
            WIRE_FIXED64: begin
              dec_phase  = PH_FIXED;
              dec_remain = FIXED64_BYTES;
            end
            WIRE_FIXED32: begin
              dec_phase  = PH_FIXED;
              dec_remain = FIXED32_BYTES;
            end
            WIRE_LENGTH: begin
              dec_phase = PH_LEN;
            end
            default: begin
              t   = error_token(ERR_BAD_WIRE, dec_field, dec_wire, fin);
              hit = 1'b1;
            end
          endcase
          // a tag that closes the message leaves its body missing
          if (!hit && fin) begin
            t   = error_token(ERR_TRUNCATED, dec_field, dec_wire, fin);
            hit = 1'b1;
          end
        end
      end
      PH_VARVAL, PH_LEN: begin
        r = varint_take(b);
        if (r == VB_OVERLONG) begin
          t   = error_token(ERR_OVERLONG, dec_field, dec_wire, fin);
          hit = 1'b1;
        end else if (r == VB_MORE) begin
          if (fin) begin
            t   = error_token(ERR_TRUNCATED, dec_field, dec_wire, fin);
            hit = 1'b1;
          end
        end else begin
          v = dec_acc;
          clear_body();
          hit = 1'b1;
          if (dec_phase == PH_VARVAL) begin
            dec_phase = PH_TAG;
            t = field_token(KIND_VARINT, v, 1'b0, fin);
          end else if (v == 64'd0) begin
            // empty payload completes the field here
            dec_phase = PH_TAG;
            t = field_token(KIND_LENGTH, 64'd0, 1'b0, fin);
          end else if (fin) begin
            t = error_token(ERR_TRUNCATED, dec_field, dec_wire, fin);
          end else begin
            dec_remain = v;
            dec_phase  = PH_PAYLOAD;
            t = field_token(KIND_LENGTH, v, 1'b0, 1'b0);
          end
        end
      end
      PH_FIXED: begin
        if (dec_shift < 7'd64) dec_acc = dec_acc | ({56'd0, b} << dec_shift);
        dec_shift = dec_shift + 7'd8;
        if (dec_remain <= 64'd1) begin
          v = dec_acc;
          clear_body();
          dec_phase = PH_TAG;
          t = field_token((dec_wire == WIRE_FIXED64) ? KIND_FIXED64 : KIND_FIXED32,
                          v, 1'b0, fin);
          hit = 1'b1;
        end else begin
          dec_remain = dec_remain - 64'd1;
          if (fin) begin
            t   = error_token(ERR_TRUNCATED, dec_field, dec_wire, fin);
            hit = 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        hit = 1'b1;
        if (dec_remain <= 64'd1) begin
          clear_body();
          dec_phase = PH_TAG;
          t = field_token(KIND_PAYLOAD, {56'd0, b}, 1'b1, fin);
        end else if (fin) begin
          t = error_token(ERR_TRUNCATED, dec_field, dec_wire, fin);
        end else begin
          dec_remain = dec_remain - 64'd1;
          t = field_token(KIND_PAYLOAD, {56'd0, b}, 1'b0, 1'b0);
        end
      end
      default: begin
        // discarding after an error until the final byte
        if (fin) begin
          clear_body();
          dec_field = 32'd0;
          dec_wire  = 3'd0;
          dec_phase = PH_TAG;
        end
      end
    endcase
    if (hit) tokens_due = {tokens_due, t};
  endtask

  // ---------------------------------------------------------------------------
  // message building
  // ---------------------------------------------------------------------------

  // append one byte to the message under construction
  task automatic add_byte(input logic [7:0] b);
    msg_buf = {msg_buf, b};
  endtask

  // little-endian base-128; pad adds a redundant zero group
  task automatic put_varint(input logic [63:0] v, input bit pad);
    logic [63:0] rest;
    rest = v;
    while (rest > VARINT_LOW_MASK) begin
      add_byte(VARINT_MORE | rest[7:0]);
      rest = rest >> 7;
    end
    if (pad) begin
      add_byte(VARINT_MORE | rest[7:0]);
      add_byte(8'd0);
    end else begin
      add_byte(rest[7:0]);
    end
  endtask

  function automatic logic [63:0] rand_value();
    int          nbits;
    logic [63:0] x;
    nbits = $urandom_range(0, 64);
    x     = {$urandom, $urandom};
    if (nbits < 64) x = x & ((64'd1 << nbits) - 64'd1);
    return x;
  endfunction

  // move the first cut bytes of the buffer to the feed, final flag on the last
  task automatic flush_message(input int cut);
    msg_byte_t mb;
    for (int i = 0; i < cut; i++) begin
      mb = '{drain: 1'b0, last: (i == cut - 1), data: msg_buf[i]};
      byte_feed = {byte_feed, mb};
    end
    msg_buf.delete();
  endtask

  task automatic put_field(output bit stop);
    logic [60:0] fnum;
    logic [2:0]  wt;
    logic [63:0] len;
    int          sel;
    bit          pad;
    stop = 1'b0;
    pad  = ($urandom_range(0, 15) == 0);
    case ($urandom_range(0, 3))
      0:       fnum = 61'($urandom_range(0, 15));
      1:       fnum = 61'($urandom_range(0, 65535));
      2:       fnum = 61'($urandom);
      default: fnum = 61'({$urandom, $urandom});
    endcase
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      put_varint({fnum, WIRE_VARINT}, pad);
      put_varint(rand_value(), $urandom_range(0, 15) == 0);
    end else if (sel < 45) begin
      put_varint({fnum, WIRE_FIXED64}, pad);
      repeat (FIXED64_BYTES) add_byte(8'($urandom));
    end else if (sel < 60) begin
      put_varint({fnum, WIRE_FIXED32}, pad);
      repeat (FIXED32_BYTES) add_byte(8'($urandom));
    end else if (sel < 92) begin
      put_varint({fnum, WIRE_LENGTH}, pad);
      if ($urandom_range(0, 24) == 0) begin
        // huge length: the message must end inside the payload
        len = {$urandom, $urandom} | 64'h1_0000_0000;
        put_varint(len, 1'b0);
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
        stop = 1'b1;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(7, 24))
                                          : 64'($urandom_range(0, 6));
        put_varint(len, $urandom_range(0, 15) == 0);
        repeat (len) add_byte(8'($urandom));
      end
    end else if (sel < 96) begin
      case ($urandom_range(0, 3))
        0:       wt = WIRE_GROUP_START;
        1:       wt = WIRE_GROUP_END;
        2:       wt = WIRE_RSVD6;
        default: wt = WIRE_RSVD7;
      endcase
      put_varint({fnum, wt}, pad);
    end else begin
      // overlong varint, in the tag or in the value
      if ($urandom_range(0, 1)) put_varint({fnum, WIRE_VARINT}, 1'b0);
      repeat (VARINT_MAX_BYTES) add_byte(VARINT_MORE | 8'($urandom));
    end
  endtask

  task automatic queue_message();
    int cut;
    bit stop;
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
    end else begin
      stop = 1'b0;
      repeat ($urandom_range(1, 4)) begin
        if (!stop) put_field(stop);
      end
    end
    cut = msg_buf.size();
    if ($urandom_range(0, 4) == 0) cut = $urandom_range(1, msg_buf.size());
    flush_message(cut);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------

  initial begin
    int dir_len;
    int mid_idx;
    int total;
    // varint, fixed32, empty and one-byte length-delimited fields
    put_varint({61'd1, WIRE_VARINT}, 1'b0);
    put_varint(64'd150, 1'b0);
    put_varint({61'd3, WIRE_FIXED32}, 1'b0);
    add_byte(8'h00);
    add_byte(8'hff);
    add_byte(8'h80);
    add_byte(8'h7f);
    put_varint({61'd2, WIRE_LENGTH}, 1'b0);
    put_varint(64'd0, 1'b0);
    put_varint({61'd4, WIRE_LENGTH}, 1'b0);
    put_varint(64'd1, 1'b0);
    add_byte(8'hff);
    flush_message(msg_buf.size());
    // unknown wire type, then the rest dropped
    put_varint({61'd5, WIRE_RSVD7}, 1'b0);
    add_byte(8'h00);
    flush_message(msg_buf.size());
    // tag completes on the final byte
    put_varint({61'd1, WIRE_FIXED64}, 1'b0);
    flush_message(msg_buf.size());
    // message ends inside a tag
    add_byte(VARINT_MORE);
    flush_message(msg_buf.size());
    // overlong tag
    repeat (VARINT_MAX_BYTES) add_byte(8'hff);
    add_byte(8'h00);
    flush_message(msg_buf.size());

    dir_len = byte_feed.size();
    mid_idx = -1;
    while (byte_feed.size() - dir_len < RANDOM_BYTES) begin
      if (mid_idx < 0 && byte_feed.size() - dir_len >= RANDOM_BYTES / 2) begin
        mid_idx = byte_feed.size();
      end
      queue_message();
    end
    // sender waits for all tokens before the random part and once midway
    byte_feed[dir_len].drain = 1'b1;
    byte_feed[mid_idx].drain = 1'b1;
    total = byte_feed.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_in < total) @(posedge clk_i);
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout: %0d bytes taken, %0d tokens still due", bytes_in, tokens_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    @(posedge rst_ni);
    while (bytes_in < HOLD_AT_BYTE) @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  function automatic bit stall_now(input int mode);
    case (mode)
      0:       return 1'b0;
      1:       return $urandom_range(0, 7) == 0;
      default: return $urandom_range(0, 1) == 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // byte driver
  // ---------------------------------------------------------------------------

  int tx_idle = 0;
  int tx_mode = 0;
  int tx_tick = 0;

  always @(negedge clk_i) begin
    msg_byte_t nxt;
    if (rst_ni) begin
      tx_tick++;
      if (tx_tick % MODE_PERIOD == 0) tx_mode = $urandom_range(0, 2);
      if (!s_tvalid || in_fire) begin
        if (tx_idle > 0) begin
          tx_idle--;
          s_tvalid <= 1'b0;
        end else if (byte_feed.size() == 0 ||
                     (byte_feed[0].drain && tokens_due.size() != 0)) begin
          s_tvalid <= 1'b0;
        end else if (byte_feed.size() > TAIL_BYTES && stall_now(tx_mode)) begin
          tx_idle = $urandom_range(0, 3);
          s_tvalid <= 1'b0;
        end else begin
          nxt = byte_feed.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.data;
          s_tlast  <= nxt.last;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // token receiver ready
  // ---------------------------------------------------------------------------

  int rx_idle = 0;
  int rx_mode = 0;
  int rx_tick = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_tick++;
      if (rx_tick % MODE_PERIOD == 0) rx_mode = $urandom_range(0, 2);
      if (rx_hold) begin
        m_tready <= 1'b0;
      end else if (rx_idle > 0) begin
        rx_idle--;
        m_tready <= 1'b0;
      end else if (byte_feed.size() > TAIL_BYTES && stall_now(rx_mode)) begin
        rx_idle = $urandom_range(0, 3);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input beat capture and token prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    in_fire = rst_ni && s_tvalid && s_tready;
    if (in_fire) begin
      tokenize_byte(s_tdata, s_tlast);
      bytes_in++;
    end
  end

  // ---------------------------------------------------------------------------
  // token check
  // ---------------------------------------------------------------------------

  function automatic string token_str(input token_t t);
    return $sformatf("kind=%0d field=%0d wire=%0d value=0x%016h err=%0d plast=%0b end=%0b",
                     t.kind, t.field, t.wire_t, t.value, t.err, t.payload_last,
                     t.message_end);
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
  endtask

  always @(posedge clk_i) begin
    token_t got;
    token_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = '{kind: m_tuser[2:0], field: m_tdata[31:0], wire_t: m_tdata[34:32],
              value: m_tdata[98:35], err: m_tdata[100:99], payload_last: m_tuser[3],
              message_end: m_tlast};
      if (tokens_due.size() == 0) begin
        flag_mismatch({"token with none due: ", token_str(got)});
      end else begin
        want = tokens_due.pop_front();
        if (got.kind !== want.kind || got.field !== want.field ||
            got.wire_t !== want.wire_t || got.value !== want.value ||
            got.err !== want.err || got.payload_last !== want.payload_last ||
            got.message_end !== want.message_end) begin
          flag_mismatch({"token mismatch\n  expected ", token_str(want),
                         "\n  actual   ", token_str(got)});
        end
      end
    end
  end

endmodule

// File: protobuf_wire_tokenizer_core.f
+incdir+src
src/pwt_pkg.sv
src/pwt_decode.sv
src/pwt_out_reg.sv
src/protobuf_wire_tokenizer_core.sv
verif/tb.sv
